// ----- hdl/cooler_thermostat_with_fan_timer_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Cooler thermostat assertion macros
// Shared assertion wrappers; they expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef COOLER_THERMOSTAT_WITH_FAN_TIMER_UNIT_DEFINES_SVH
`define COOLER_THERMOSTAT_WITH_FAN_TIMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every rising edge outside of reset.
`define CTTF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cttf assertion failed");
// Property checked on every rising edge, reset included.
`define CTTF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cttf assertion failed");
`else
`define CTTF_ASSERT(lbl, clk, rstn, prop)
`define CTTF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- hdl/cttf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cooler thermostat package
// Shared types, constants and the Dallas CRC-8 byte step.
// ----------------------------------------------------------------------------
package cttf_pkg;

  // Scratchpad frame length in bytes.
  localparam int unsigned FrameBytes = 9;
  localparam int unsigned IdxW       = $clog2(FrameBytes + 1);

  // Item opcodes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SETPOINT   = 2'd0;
  localparam logic [1:0] CFG_HYSTERESIS = 2'd1;
  localparam logic [1:0] CFG_FAN_PERIOD = 2'd2;

  // Configuration reset values.
  localparam logic signed [12:0] SetpointReset   = 13'sd384;
  localparam logic [10:0]        HysteresisReset = 11'd64;
  localparam logic [15:0]        FanPeriodReset  = 16'd20000;

  // Reflected polynomial of the Dallas CRC-8.
  localparam logic [7:0] CrcPoly = 8'h8C;

  // Event handed from the frame unit to the controller.
  typedef struct packed {
    logic        good;  // frame finished, CRC matched
    logic        bad;   // frame finished, CRC mismatch
    logic [15:0] raw;   // sensor reading, 1/16 degree C
  } frame_evt_t;

  // One result word.
  typedef struct packed {
    logic signed [16:0] temperature;
    logic               accepted;
    logic               crc_error;
    logic               cooling;
    logic               intake;
  } result_t;

  // One byte of the CRC, bit serial, LSB first.
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/cttf_frame.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cooler thermostat frame unit
// Tracks the byte position in a scratchpad frame, runs the CRC and keeps the
// two reading bytes; flags the frame end as good or bad.
// ----------------------------------------------------------------------------
`include "cooler_thermostat_with_fan_timer_unit_defines.svh"

module cttf_frame (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 op_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 frame_first_i,
  output cttf_pkg::frame_evt_t evt_o
);

  localparam logic [cttf_pkg::IdxW-1:0] IdxNone = cttf_pkg::IdxW'(cttf_pkg::FrameBytes);
  localparam logic [cttf_pkg::IdxW-1:0] IdxLast = cttf_pkg::IdxW'(cttf_pkg::FrameBytes - 1);
  localparam logic [cttf_pkg::IdxW-1:0] IdxLow  = cttf_pkg::IdxW'(0);
  localparam logic [cttf_pkg::IdxW-1:0] IdxHigh = cttf_pkg::IdxW'(1);

  logic [cttf_pkg::IdxW-1:0] idx_q, idx_d, idx_eff;
  logic [7:0]                crc_q, crc_d, crc_eff;
  logic [7:0]                low_q, low_d, high_q, high_d;
  logic                      byte_en;

  assign byte_en = en_i && (op_i == cttf_pkg::OP_BYTE);

  // A first-byte mark restarts the frame at position zero.
  assign idx_eff = frame_first_i ? '0 : idx_q;
  assign crc_eff = frame_first_i ? '0 : crc_q;

  // Next frame state and end-of-frame word.
  always_comb begin
    idx_d        = idx_q;
    crc_d        = crc_q;
    low_d        = low_q;
    high_d       = high_q;
    evt_o.good   = 1'b0;
    evt_o.bad    = 1'b0;
    evt_o.raw    = {high_q, low_q};
    if (byte_en) begin
      idx_d = idx_eff;
      crc_d = crc_eff;
      if (idx_eff < IdxNone) begin
        if (idx_eff == IdxLow) begin
          low_d = data_byte_i;
        end else if (idx_eff == IdxHigh) begin
          high_d = data_byte_i;
        end
        if (idx_eff < IdxLast) begin
          crc_d = cttf_pkg::crc_step(crc_eff, data_byte_i);
        end else if (crc_eff == data_byte_i) begin
          evt_o.good = 1'b1;
        end else begin
          evt_o.bad = 1'b1;
        end
        idx_d = idx_eff + 1'b1;
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= IdxNone;
      crc_q  <= '0;
      low_q  <= '0;
      high_q <= '0;
    end else begin
      idx_q  <= idx_d;
      crc_q  <= crc_d;
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  // The position never runs past the idle marker.
  `CTTF_ASSERT(a_idx_range, clk_i, rst_ni, idx_q <= IdxNone)
  // A frame end is reported only for a byte that sat at the last position.
  `CTTF_ASSERT(a_end_pos, clk_i, rst_ni, (evt_o.good || evt_o.bad) |=> idx_q == IdxNone)

endmodule

// ----- hdl/cttf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cooler thermostat controller
// Holds the accepted temperature, applies the trend-gated hysteresis rule
// and runs the intake fan timer; returns the next result word.
// ----------------------------------------------------------------------------
`include "cooler_thermostat_with_fan_timer_unit_defines.svh"

module cttf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  op_i,
  input  cttf_pkg::frame_evt_t  evt_i,
  input  logic signed [12:0]    setpoint_i,
  input  logic [10:0]           hysteresis_i,
  input  logic [15:0]           fan_period_i,
  output cttf_pkg::result_t     res_o
);

  logic signed [16:0] cur_q, cur_d, prev_q, prev_d, t_new;
  logic               cool_q, cool_d, intake_q, intake_d;
  logic [15:0]        ticks_q, ticks_d, ticks_inc;
  logic signed [17:0] upper, t_ext, prev_ext, sp_ext;

  // Reading R becomes 2R+1 in 1/32 degree C.
  assign t_new    = {evt_i.raw, 1'b1};
  assign t_ext    = 18'(t_new);
  assign prev_ext = 18'(prev_q);
  assign sp_ext   = 18'(setpoint_i);
  assign upper    = sp_ext + $signed({7'b0, hysteresis_i});

  // Saturating tick count.
  assign ticks_inc = (ticks_q != 16'hFFFF) ? ticks_q + 16'd1 : ticks_q;

  // Next controller state.
  always_comb begin
    cur_d    = cur_q;
    prev_d   = prev_q;
    cool_d   = cool_q;
    intake_d = intake_q;
    ticks_d  = ticks_q;
    if (en_i) begin
      if (op_i == cttf_pkg::OP_TICK) begin
        ticks_d = ticks_inc;
        if (cool_q) begin
          if (ticks_inc >= fan_period_i) begin
            intake_d = !intake_q;
            ticks_d  = '0;
          end
        end else begin
          intake_d = 1'b0;
        end
      end else if (evt_i.good) begin
        cur_d  = t_new;
        prev_d = t_new;
        if (t_ext > prev_ext) begin
          if (t_ext > upper) begin
            cool_d = 1'b1;
          end
        end else if (t_ext < prev_ext) begin
          if (t_ext <= sp_ext) begin
            cool_d = 1'b0;
          end
        end
        if (!cool_d) begin
          intake_d = 1'b0;
        end
      end
    end
  end

  // Result word reflects the state after this word.
  always_comb begin
    res_o.temperature = cur_d;
    res_o.accepted    = en_i && (op_i == cttf_pkg::OP_BYTE) && evt_i.good;
    res_o.crc_error   = en_i && (op_i == cttf_pkg::OP_BYTE) && evt_i.bad;
    res_o.cooling     = cool_d;
    res_o.intake      = intake_d;
  end

  // Controller state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      prev_q   <= '0;
      cool_q   <= 1'b0;
      intake_q <= 1'b0;
      ticks_q  <= '0;
    end else begin
      cur_q    <= cur_d;
      prev_q   <= prev_d;
      cool_q   <= cool_d;
      intake_q <= intake_d;
      ticks_q  <= ticks_d;
    end
  end

  // The intake fan never runs while the cooler is off.
  `CTTF_ASSERT_ALWAYS(a_intake_needs_cool, clk_i, !cool_q |-> !intake_q)
  // Cooling only starts on a good frame.
  `CTTF_ASSERT(a_cool_on_frame, clk_i, rst_ni,
    $rose(cool_q) |-> $past(en_i && op_i == cttf_pkg::OP_BYTE && evt_i.good))

endmodule

// ----- hdl/cooler_thermostat_with_fan_timer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cooler thermostat with fan timer
// Checks sensor scratchpad frames by CRC-8, runs a hysteresis cooler rule and
// times the intake fan from millisecond ticks; one result word per input.
// ----------------------------------------------------------------------------
// The block takes one input word per clock while the result channel is not
// stalled and returns exactly one result word for each: the word is captured
// in an input register, the frame unit and controller update from it, and the
// outcome lands in the result register. When the result is stalled, one more
// input word is still taken into the input register; after that the input
// waits until the result is taken. Configuration writes take effect on the
// next edge and are expected only while no word is in flight.
// ----------------------------------------------------------------------------
`include "cooler_thermostat_with_fan_timer_unit_defines.svh"

module cooler_thermostat_with_fan_timer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_first_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] temperature_o,
  output logic               reading_accepted_o,
  output logic               crc_error_o,
  output logic               cooler_on_o,
  output logic               cooler_drive_n_o,
  output logic               intake_fan_o,
  output logic               exhaust_fan_o
);

  logic                 in_valid_q, out_valid_q, out_free, advance;
  logic                 op_q, first_q;
  logic [7:0]           byte_q;
  logic signed [12:0]   setpoint_q;
  logic [10:0]          hysteresis_q;
  logic [15:0]          fan_period_q;
  cttf_pkg::frame_evt_t evt;
  cttf_pkg::result_t    res_d, res_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q   <= cttf_pkg::SetpointReset;
      hysteresis_q <= cttf_pkg::HysteresisReset;
      fan_period_q <= cttf_pkg::FanPeriodReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cttf_pkg::CFG_SETPOINT:   setpoint_q   <= cfg_wdata_i[12:0];
        cttf_pkg::CFG_HYSTERESIS: hysteresis_q <= cfg_wdata_i[10:0];
        cttf_pkg::CFG_FAN_PERIOD: fan_period_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: the input stage advances whenever the result register is free.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= op_i;
      byte_q  <= data_byte_i;
      first_q <= frame_first_i;
    end
  end

  cttf_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .op_i          (op_q),
    .data_byte_i   (byte_q),
    .frame_first_i (first_q),
    .evt_o         (evt)
  );

  cttf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .op_i         (op_q),
    .evt_i        (evt),
    .setpoint_i   (setpoint_q),
    .hysteresis_i (hysteresis_q),
    .fan_period_i (fan_period_q),
    .res_o        (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign temperature_o      = res_q.temperature;
  assign reading_accepted_o = res_q.accepted;
  assign crc_error_o        = res_q.crc_error;
  assign cooler_on_o        = res_q.cooling;
  assign cooler_drive_n_o   = !res_q.cooling;
  assign intake_fan_o       = res_q.intake;
  assign exhaust_fan_o      = res_q.cooling;

  // A result word never reports a good and a bad frame at once.
  `CTTF_ASSERT(a_good_bad_excl, clk_i, rst_ni, out_valid_q |-> !(res_q.accepted && res_q.crc_error))
  // A word held in the input stage while the result stalls is not lost.
  `CTTF_ASSERT(a_in_hold, clk_i, rst_ni, (in_valid_q && !out_free) |=> in_valid_q)

endmodule
